[rtl/wrt_pkg.sv]
`default_nettype none
package wrt_pkg;
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic {REQ_ADD = 1'b0, REQ_LOOKUP = 1'b1} req_kind_type;

   typedef struct packed {
      logic        req_type;
      logic [31:0] dest_ip;
      logic [7:0]  new_device;
      logic [31:0] new_network;
      logic [31:0] new_gateway;
      logic [31:0] new_mask;
      logic [15:0] new_weight;
   } req_type;

   typedef struct packed {
      logic        status;
      logic        found;
      logic [7:0]  hit_device;
      logic [31:0] hit_gateway;
      logic [15:0] hit_weight;
   } rsp_type;

   // classified command passed from front to back
   typedef struct packed {
      logic              is_lookup;
      logic              full;
      logic [IDX_W-1:0]  slot;
      req_type           req;
   } cmd_type;

   typedef enum logic [1:0] {BK_IDLE, BK_SCAN, BK_DONE} back_state_type;
endpackage
`default_nettype wire

[rtl/weighted_route_table.sv]
// Add: the command passes through the queue; the result is registered. Lookup:
// the scan reads one slot per cycle from the route memory.
// One add per cycle while no scan runs; commands wait while a lookup scans.
// Up to two requests wait in the command queue; busy is high while it is full.
// Synchronous reset empties the queue and marks every slot free.
// The receiver cannot stall: rsp_valid lasts exactly one cycle.
`default_nettype none
module weighted_route_table (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire wrt_pkg::req_type req_data,
   output logic                  rsp_valid,
   output wrt_pkg::rsp_type      rsp_data
);
   import wrt_pkg::*;

   logic                   push, q_full, pop, not_empty;
   cmd_type                push_cmd, head;

   wrt_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req_data),
      .push(push), .push_cmd(push_cmd), .q_full(q_full)
   );

   wrt_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_cmd(push_cmd),
      .full(q_full), .pop(pop), .not_empty(not_empty), .head(head)
   );

   wrt_back u_back (
      .clock(clock), .reset(reset), .not_empty(not_empty), .head(head),
      .pop(pop), .rsp_valid(rsp_valid), .rsp(rsp_data)
   );
endmodule
`default_nettype wire

[rtl/wrt_front.sv]
`default_nettype none
// Accepts requests, picks the free slot for adds, tracks slot occupancy.
module wrt_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire wrt_pkg::req_type req,
   output logic                  push,
   output wrt_pkg::cmd_type      push_cmd,
   input  wire logic             q_full
);
   import wrt_pkg::*;

   logic [TABLE_DEPTH-1:0] used_ff, used_in;
   logic [IDX_W-1:0]       free_idx;
   logic                   any_free;

   // priority encode lowest free slot
   always_comb begin
      free_idx = '0;
      any_free = 1'b0;
      for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
         if (!used_ff[k]) begin
            free_idx = IDX_W'(k);
            any_free = 1'b1;
         end
      end
   end

   assign busy = q_full;
   assign push = start && !q_full;

   always_comb begin
      push_cmd.is_lookup = (req.req_type == REQ_LOOKUP);
      push_cmd.full      = !any_free;
      push_cmd.slot      = free_idx;
      push_cmd.req       = req;
      used_in = used_ff;
      if (push && req.req_type == REQ_ADD && any_free) begin
         used_in[free_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end
endmodule
`default_nettype wire

[rtl/wrt_queue.sv]
`default_nettype none
module wrt_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire wrt_pkg::cmd_type push_cmd,
   output logic                  full,
   input  wire logic             pop,
   output logic                  not_empty,
   output wrt_pkg::cmd_type      head
);
   import wrt_pkg::*;

   cmd_type   entry_ff [QUEUE_DEPTH];
   logic      wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ pop;
      cnt_in  = cnt_ff + 2'(push) - 2'(pop);
   end

   assign full      = (cnt_ff == 2'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = entry_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_cmd;
      end
   end
endmodule
`default_nettype wire

[rtl/wrt_back.sv]
`default_nettype none
// Executes commands: a memory write for add (none when full), one slot per cycle for lookup.
module wrt_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             not_empty,
   input  wire wrt_pkg::cmd_type head,
   output logic                  pop,
   output logic                  rsp_valid,
   output wrt_pkg::rsp_type      rsp
);
   import wrt_pkg::*;

   typedef struct packed {
      logic [7:0]  device;
      logic [31:0] network;
      logic [31:0] gateway;
      logic [31:0] mask;
      logic [15:0] weight;
   } slot_type;

   slot_type         mem [TABLE_DEPTH];
   slot_type         rd_ff;
   back_state_type   state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             rd_used_ff;
   logic [31:0]      dst_ff, dst_in;
   rsp_type          best_ff, best_in, rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             match;
   logic             wr_en;
   // slots written so far, one bit per slot
   logic [TABLE_DEPTH-1:0] live_ff, live_in;

   assign match = rd_vld_ff && rd_used_ff &&
                  ((rd_ff.mask & dst_ff) == (rd_ff.network & rd_ff.mask));

   assign wr_en = (state_ff == BK_IDLE) && not_empty && !head.is_lookup && !head.full;

   always_comb begin
      live_in = live_ff;
      if (wr_en) begin
         live_in[head.slot] = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      dst_in       = dst_ff;
      best_in      = best_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      rd_vld_in    = 1'b0;
      pop          = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (not_empty) begin
               pop = 1'b1;
               if (head.is_lookup) begin
                  state_in  = BK_SCAN;
                  idx_in    = '0;
                  dst_in    = head.req.dest_ip;
                  best_in   = '0;
               end else begin
                  rsp_in        = '0;
                  rsp_in.status = head.full;
                  rsp_valid_in  = 1'b1;
               end
            end
         end
         BK_SCAN: begin
            // read issued for idx_ff, compared from rd_ff in the following cycle
            if (match && rd_ff.weight > best_ff.hit_weight) begin
               best_in.found       = 1'b1;
               best_in.hit_device  = rd_ff.device;
               best_in.hit_gateway = rd_ff.gateway;
               best_in.hit_weight  = rd_ff.weight;
            end
            if (idx_ff == CNT_W'(TABLE_DEPTH)) begin
               state_in = BK_DONE;
            end else begin
               rd_vld_in = 1'b1;
               idx_in    = idx_ff + 1'b1;
            end
         end
         BK_DONE: begin
            if (match && rd_ff.weight > best_ff.hit_weight) begin
               best_in.found       = 1'b1;
               best_in.hit_device  = rd_ff.device;
               best_in.hit_gateway = rd_ff.gateway;
               best_in.hit_weight  = rd_ff.weight;
            end
            rsp_in       = best_in;
            rsp_valid_in = 1'b1;
            state_in     = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         live_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
         live_ff      <= live_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      dst_ff  <= dst_in;
      best_ff <= best_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[head.slot] <= '{device:  head.req.new_device,
                             network: head.req.new_network,
                             gateway: head.req.new_gateway,
                             mask:    head.req.new_mask,
                             weight:  head.req.new_weight};
      end
      rd_ff      <= mem[idx_ff[IDX_W-1:0]];
      rd_used_ff <= live_ff[idx_ff[IDX_W-1:0]];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
endmodule
`default_nettype wire

[rtl/wrt_checker.sv]
`default_nettype none
module wrt_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire wrt_pkg::rsp_type rsp_data
);
   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.hit_weight == 16'd0 &&
      rsp_data.hit_device == 8'd0 && rsp_data.hit_gateway == 32'd0)
      else $error("not found result carries data");
   a_found_weight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |-> rsp_data.hit_weight != 16'd0)
      else $error("found with zero weight");
   a_status_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.status && rsp_data.found))
      else $error("full status and found together");
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid && !busy)
      else $error("activity right after reset");
endmodule

bind weighted_route_table wrt_checker u_wrt_checker (
   .clock(clock), .reset(reset), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import wrt_pkg::*;

   localparam int MAX_CYCLES = 400000;
   localparam int REQ_W = $bits(req_type);

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   weighted_route_table uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // route table copy used for prediction
   logic        route_used [TABLE_DEPTH];
   logic [7:0]  route_dev  [TABLE_DEPTH];
   logic [31:0] route_net  [TABLE_DEPTH];
   logic [31:0] route_gw   [TABLE_DEPTH];
   logic [31:0] route_mask [TABLE_DEPTH];
   logic [15:0] route_wt   [TABLE_DEPTH];

   rsp_type pending_routes[$];
   int      errors = 0;
   int      cycles = 0;
   bit      gaps_on = 1'b1;

   function automatic rsp_type route_predict(req_type r);
      rsp_type     res;
      logic [15:0] best;
      bit          stored;
      res = '0;
      best = '0;
      stored = 1'b0;
      if (r.req_type == REQ_ADD) begin
         for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (!stored && !route_used[k]) begin
               route_used[k] = 1'b1;
               route_dev[k] = r.new_device;
               route_net[k] = r.new_network;
               route_gw[k] = r.new_gateway;
               route_mask[k] = r.new_mask;
               route_wt[k] = r.new_weight;
               stored = 1'b1;
            end
         end
         res.status = !stored;
      end else begin
         for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (route_used[k] && ((route_mask[k] & r.dest_ip) ==
                                  (route_net[k] & route_mask[k])) &&
                route_wt[k] > best) begin
               best = route_wt[k];
               res.found = 1'b1;
               res.hit_device = route_dev[k];
               res.hit_gateway = route_gw[k];
               res.hit_weight = route_wt[k];
            end
         end
      end
      return res;
   endfunction

   // start stays high between back-to-back transactions
   task automatic send_request(req_type r);
      int gap;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_routes.push_back(route_predict(r));
   endtask

   // idle check: waits for every pending result; transaction results come out in order
   task automatic wait_drained();
      start <= 1'b0;
      while (pending_routes.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLES) begin
         $display("FAIL weighted_route_table");
         $finish;
      end
      if (!reset && rsp_valid) begin
         if (pending_routes.size() == 0) begin
            $display("%0t unexpected result %h", $time, rsp_data);
            errors <= errors + 1;
         end else begin
            if (rsp_data !== pending_routes[0]) begin
               $display("%0t mismatch: expected st=%b f=%b dev=%h gw=%h wt=%h",
                        $time, pending_routes[0].status, pending_routes[0].found,
                        pending_routes[0].hit_device, pending_routes[0].hit_gateway,
                        pending_routes[0].hit_weight);
               $display("%0t           actual   st=%b f=%b dev=%h gw=%h wt=%h",
                        $time, rsp_data.status, rsp_data.found, rsp_data.hit_device,
                        rsp_data.hit_gateway, rsp_data.hit_weight);
               errors <= errors + 1;
            end
            void'(pending_routes.pop_front());
         end
      end
   end

   function automatic req_type rand_add(logic [15:0] wt);
      req_type r;
      r = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      r.req_type = REQ_ADD;
      r.new_weight = wt;
      // mostly short prefixes so lookups hit often
      case ($urandom_range(0, 3))
         0: r.new_mask = '0;
         1: r.new_mask = 32'hFFFF_FFFF << $urandom_range(24, 32);
         2: r.new_mask = 32'hFFFF_FFFF << $urandom_range(0, 32);
         default: r.new_mask = $urandom;
      endcase
      r.new_network[31:28] = 4'($urandom_range(0, 1));
      return r;
   endfunction

   function automatic req_type rand_lookup();
      req_type r;
      r = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      r.req_type = REQ_LOOKUP;
      if ($urandom_range(0, 3) != 0) r.dest_ip[31:28] = 4'($urandom_range(0, 1));
      return r;
   endfunction

   task automatic do_reset();
      for (int k = 0; k < TABLE_DEPTH; k++) route_used[k] = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_directed();
      req_type r;
      r = rand_lookup();
      r.dest_ip = '0;
      send_request(r);                     // empty table
      r = '1;
      r.req_type = REQ_ADD;                // all-ones route, max weight
      r.new_mask = '0;
      send_request(r);
      r = '0;
      r.req_type = REQ_ADD;                // weight 0 match-everything route
      send_request(r);
      r = '1;
      r.req_type = REQ_LOOKUP;
      send_request(r);
      r = '0;
      r.req_type = REQ_LOOKUP;
      send_request(r);
      // tie: equal weights, lower slot must win
      r = rand_add(16'h7000);
      r.new_mask = 32'hFFFF_FF00;
      r.new_network = 32'h0A00_0100;
      send_request(r);
      r.new_device = ~r.new_device;
      r.new_gateway = ~r.new_gateway;
      send_request(r);                     // duplicate route
      r = '1;
      r.req_type = REQ_LOOKUP;
      r.dest_ip = 32'h0A00_01FF;
      send_request(r);
      for (int k = 0; k < 12; k++) send_request(rand_add(16'($urandom_range(0, 3))));
      send_request(rand_add(16'h1234));    // table full
      r = '0;
      r.req_type = REQ_ADD;
      send_request(r);                     // full again, all zero
      send_request(rand_lookup());
      wait_drained();
   endtask

   task automatic test_random();
      for (int n = 0; n < 1800; n++) begin
         if (n == 1500) gaps_on = 1'b0;
         // table is full from the directed phase, so adds exercise the full case
         if (n < 16 || $urandom_range(0, 9) == 0) begin
            send_request(rand_add($urandom_range(0, 1) ? 16'($urandom) :
                                  16'($urandom_range(0, 2))));
         end else begin
            send_request(rand_lookup());
         end
      end
   endtask

   initial begin
      do_reset();
      test_directed();
      test_random();
      wait_drained();
      repeat (30) @(posedge clock);
      if (errors == 0 && pending_routes.size() == 0) begin
         $display("PASS weighted_route_table");
      end else begin
         $display("FAIL weighted_route_table");
      end
      $finish;
   end
endmodule
`default_nettype wire
